@@ rtl/whbt_pkg.sv @@
// ----------------------------------------------------------------------------
// Weighted hash bucket table package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package whbt_pkg;

   localparam int MAX_MEMBERS = 16;
   localparam int MAX_BUCKETS = 256;
   localparam int MIN_SIZE    = 16;
   localparam int IDX_W       = 4;
   localparam int CNT_W       = 5;
   localparam int ADDR_W      = 8;
   localparam int BCNT_W      = 9;
   localparam int SIZE_W      = 10;
   localparam int DIV_W       = 10;
   localparam int TOT_W       = 36;
   localparam int PROD_W      = 42;
   localparam int CSR_W       = 17;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_BUILD  = 2'd1,
      FUNC_ALIVE  = 2'd2,
      FUNC_SELECT = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_COUNT   = 3'd1,
      ST_ZERO_WEIGHT = 3'd2,
      ST_TOO_LARGE   = 3'd3,
      ST_NO_MEMBER   = 3'd4
   } status_type;

   typedef struct packed {
      logic       capture;
      logic       drop;
      logic       sum_init;
      logic       sum_step;
      logic       size_init;
      logic       size_step;
      logic       bkt_start;
      logic       win_init;
      logic       mul;
      logic       cmp;
      logic       upd;
      logic       commit;
      logic       sel_init;
      logic       sel_step;
      logic       sel_hit;
      logic       finish;
      status_type code;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic count_bad;
      logic sum_last;
      logic total_zero;
      logic size_grow;
      logic size_fail;
      logic single;
      logic inner_last;
      logic bkt_last;
      logic table_empty;
      logic alive_hit;
      logic probe_last;
   } flags_type;

endpackage

@@ rtl/whbt_datapath.sv @@
// ----------------------------------------------------------------------------
// Weighted hash bucket table datapath
// Weight, divisor and bucket stores, sizing, apportionment and probing.
// ----------------------------------------------------------------------------
module whbt_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  whbt_pkg::cmd_type             cmd,
   output whbt_pkg::flags_type           flags,
   input  logic                          csr_wr_en,
   input  logic [16:0]                   csr_wr_data,
   input  logic [1:0]                    req_func,
   input  logic [3:0]                    req_member_index,
   input  logic [31:0]                   req_weight,
   input  logic [4:0]                    req_member_count,
   input  logic                          req_alive,
   input  logic [31:0]                   req_hash,
   output logic [2:0]                    rsp_status,
   output logic [8:0]                    rsp_table_size,
   output logic [3:0]                    rsp_member
);
   import whbt_pkg::*;

   logic [CSR_W-1:0]  max_size_ff;
   logic [31:0]       weight_ff [MAX_MEMBERS];
   logic [DIV_W-1:0]  div_ff [MAX_MEMBERS];
   logic [IDX_W-1:0]  table_mem [MAX_BUCKETS];
   logic [IDX_W-1:0]  rd_data_ff;
   logic [MAX_MEMBERS-1:0] alive_ff;
   logic [BCNT_W-1:0] bcount_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ADDR_W-1:0] hash_ff;
   logic [IDX_W-1:0]  i_ff;
   logic [TOT_W-1:0]  total_ff;
   logic [31:0]       wmin_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [ADDR_W-1:0] b_ff;
   logic [IDX_W-1:0]  win_ff;
   logic [31:0]       wwin_ff;
   logic [DIV_W-1:0]  dwin_ff;
   logic [PROD_W-1:0] lhs_ff;
   logic [PROD_W-1:0] rhs_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] probe_ff;
   logic [2:0]        status_ff;
   logic [IDX_W-1:0]  member_ff;
   logic [2:0]        rsp_status_ff;
   logic [8:0]        rsp_size_ff;
   logic [3:0]        rsp_member_ff;

   logic [IDX_W-1:0]  rd_idx;
   logic [31:0]       w_rd;
   logic [DIV_W-1:0]  d_rd;
   logic [TOT_W+SIZE_W-1:0] size_prod;
   logic [ADDR_W-1:0] mask;

   assign rd_idx    = cmd.win_init ? '0 : i_ff;
   assign w_rd      = weight_ff[rd_idx];
   assign d_rd      = div_ff[rd_idx];
   assign size_prod = (TOT_W+SIZE_W)'(size_ff) * (TOT_W+SIZE_W)'(wmin_ff);
   assign mask      = ADDR_W'(bcount_ff - 9'd1);

   always_comb begin
      flags.count_bad   = (count_ff == '0) || (count_ff > CNT_W'(MAX_MEMBERS));
      flags.sum_last    = ({1'b0, i_ff} == count_ff - 5'd1);
      flags.total_zero  = (total_ff == '0);
      flags.size_grow   = (size_ff <= SIZE_W'(MAX_BUCKETS)) &&
                          ((size_prod < (TOT_W+SIZE_W)'(total_ff)) ||
                           (size_ff < SIZE_W'({count_ff, 2'b00})));
      flags.size_fail   = (size_ff > SIZE_W'(MAX_BUCKETS)) ||
                          ((max_size_ff != '0) && (CSR_W'(size_ff) > max_size_ff));
      flags.single      = (count_ff == 5'd1);
      flags.inner_last  = ({1'b0, i_ff} == count_ff - 5'd1);
      flags.bkt_last    = ({2'b00, b_ff} == size_ff - 10'd1);
      flags.table_empty = (bcount_ff == '0);
      flags.alive_hit   = alive_ff[rd_data_ff];
      flags.probe_last  = ({1'b0, probe_ff} == bcount_ff - 9'd1);
   end

   // Control-relevant state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= '0;
         alive_ff    <= '1;
         bcount_ff   <= '0;
         for (int k = 0; k < MAX_MEMBERS; k++) begin
            weight_ff[k] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            max_size_ff <= csr_wr_data;
         end
         if (cmd.capture && (func_type'(req_func) == FUNC_LOAD)) begin
            weight_ff[req_member_index] <= req_weight;
         end
         if (cmd.capture && (func_type'(req_func) == FUNC_ALIVE)) begin
            alive_ff[req_member_index] <= req_alive;
         end
         if (cmd.drop) begin
            bcount_ff <= '0;
         end else if (cmd.commit) begin
            bcount_ff <= size_ff[BCNT_W-1:0];
         end
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         count_ff  <= req_member_count;
         hash_ff   <= req_hash[ADDR_W-1:0];
         member_ff <= '0;
      end
      if (cmd.sum_init) begin
         i_ff     <= '0;
         total_ff <= '0;
         wmin_ff  <= '0;
      end
      if (cmd.sum_step) begin
         total_ff   <= total_ff + TOT_W'(w_rd);
         if ((w_rd != '0) && ((wmin_ff == '0) || (w_rd < wmin_ff))) begin
            wmin_ff <= w_rd;
         end
         div_ff[i_ff] <= DIV_W'(1);
         i_ff         <= i_ff + 4'd1;
      end
      if (cmd.size_init) begin
         size_ff <= SIZE_W'(MIN_SIZE);
      end
      if (cmd.size_step) begin
         size_ff <= {size_ff[SIZE_W-2:0], 1'b0};
      end
      if (cmd.bkt_start) begin
         b_ff <= '0;
      end
      if (cmd.win_init) begin
         win_ff  <= '0;
         wwin_ff <= w_rd;
         dwin_ff <= d_rd;
         i_ff    <= 4'd1;
      end
      if (cmd.mul) begin
         lhs_ff <= PROD_W'(w_rd) * PROD_W'(dwin_ff);
         rhs_ff <= PROD_W'(wwin_ff) * PROD_W'(d_rd);
      end
      if (cmd.cmp) begin
         if (lhs_ff > rhs_ff) begin
            win_ff  <= i_ff;
            wwin_ff <= w_rd;
            dwin_ff <= d_rd;
         end
         i_ff <= i_ff + 4'd1;
      end
      if (cmd.upd) begin
         div_ff[win_ff] <= dwin_ff + DIV_W'(2);
         b_ff           <= b_ff + 8'd1;
      end
      if (cmd.sel_init) begin
         addr_ff  <= hash_ff & mask;
         probe_ff <= '0;
      end
      if (cmd.sel_step) begin
         addr_ff  <= (addr_ff + 8'd1) & mask;
         probe_ff <= probe_ff + 8'd1;
      end
      if (cmd.sel_hit) begin
         member_ff <= rd_data_ff;
      end
      if (cmd.finish) begin
         status_ff <= cmd.code;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_size_ff   <= bcount_ff;
         rsp_member_ff <= member_ff;
      end
   end

   // Bucket store with registered read.
   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         table_mem[b_ff] <= win_ff;
      end
      rd_data_ff <= table_mem[addr_ff];
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_table_size = rsp_size_ff;
   assign rsp_member     = rsp_member_ff;

endmodule

@@ rtl/whbt_controller.sv @@
// ----------------------------------------------------------------------------
// Weighted hash bucket table controller
// Sequences build, select and store transactions over the datapath.
// ----------------------------------------------------------------------------
module whbt_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  whbt_pkg::flags_type  flags,
   output whbt_pkg::cmd_type    cmd
);
   import whbt_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_CHECK     = 13'b0000000000010,
      S_SUM       = 13'b0000000000100,
      S_SIZE_INIT = 13'b0000000001000,
      S_SIZE      = 13'b0000000010000,
      S_BKT_INIT  = 13'b0000000100000,
      S_MUL       = 13'b0000001000000,
      S_CMP       = 13'b0000010000000,
      S_UPD       = 13'b0000100000000,
      S_SEL_START = 13'b0001000000000,
      S_SEL_RD    = 13'b0010000000000,
      S_SEL_CHK   = 13'b0100000000000,
      S_DONE      = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.code = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (func_type'(req_func))
                  FUNC_BUILD:  state_in = S_CHECK;
                  FUNC_SELECT: state_in = S_SEL_START;
                  default: begin
                     cmd.finish = 1'b1;
                     state_in   = S_DONE;
                  end
               endcase
            end
         end
         S_CHECK: begin
            cmd.drop = 1'b1;
            if (flags.count_bad) begin
               cmd.finish = 1'b1;
               cmd.code   = ST_BAD_COUNT;
               state_in   = S_DONE;
            end else begin
               cmd.sum_init = 1'b1;
               state_in     = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (flags.sum_last) begin
               state_in = S_SIZE_INIT;
            end
         end
         S_SIZE_INIT: begin
            if (flags.total_zero) begin
               cmd.finish = 1'b1;
               cmd.code   = ST_ZERO_WEIGHT;
               state_in   = S_DONE;
            end else begin
               cmd.size_init = 1'b1;
               state_in      = S_SIZE;
            end
         end
         S_SIZE: begin
            priority if (flags.size_grow) begin
               cmd.size_step = 1'b1;
            end else if (flags.size_fail) begin
               cmd.finish = 1'b1;
               cmd.code   = ST_TOO_LARGE;
               state_in   = S_DONE;
            end else begin
               cmd.bkt_start = 1'b1;
               state_in      = S_BKT_INIT;
            end
         end
         S_BKT_INIT: begin
            cmd.win_init = 1'b1;
            state_in     = flags.single ? S_UPD : S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = flags.inner_last ? S_UPD : S_MUL;
         end
         S_UPD: begin
            cmd.upd = 1'b1;
            if (flags.bkt_last) begin
               cmd.commit = 1'b1;
               cmd.finish = 1'b1;
               state_in   = S_DONE;
            end else begin
               state_in = S_BKT_INIT;
            end
         end
         S_SEL_START: begin
            if (flags.table_empty) begin
               cmd.finish = 1'b1;
               cmd.code   = ST_NO_MEMBER;
               state_in   = S_DONE;
            end else begin
               cmd.sel_init = 1'b1;
               state_in     = S_SEL_RD;
            end
         end
         S_SEL_RD: begin
            state_in = S_SEL_CHK;
         end
         S_SEL_CHK: begin
            priority if (flags.alive_hit) begin
               cmd.sel_hit = 1'b1;
               cmd.finish  = 1'b1;
               state_in    = S_DONE;
            end else if (flags.probe_last) begin
               cmd.finish = 1'b1;
               cmd.code   = ST_NO_MEMBER;
               state_in   = S_DONE;
            end else begin
               cmd.sel_step = 1'b1;
               state_in     = S_SEL_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/weighted_hash_bucket_table.sv @@
// Each transaction runs alone: a build scores one member at a time with the
// shared pair of cross-multipliers, and a select reads one bucket per probe.
// Throughput: one transaction at a time; the next is taken the cycle after the
// result is loaded into the output register.
// Reset is synchronous and active high; it clears the weights, the table
// (empty), the size limit, and marks every member alive.
// ----------------------------------------------------------------------------
// Weighted hash bucket table
// Builds a power-of-two bucket table by odd-divisor apportionment of member
// weights and maps packet hashes to live members.
// ----------------------------------------------------------------------------
module weighted_hash_bucket_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [16:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_member_index,
   input  logic [31:0] req_weight,
   input  logic [4:0]  req_member_count,
   input  logic        req_alive,
   input  logic [31:0] req_hash,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [8:0]  rsp_table_size,
   output logic [3:0]  rsp_member
);
   import whbt_pkg::*;

   // The controller issues one command word per cycle and branches on the
   // datapath flags. All data storage lives in the datapath.
   cmd_type   cmd;
   flags_type flags;

   // Sequencer: a request is taken only in the idle state. The finished
   // transaction moves into the output register, and the block goes back to
   // idle even while that result is still being stalled downstream.
   whbt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   // Datapath: a build sums weights and finds the smallest nonzero one, then
   // doubles the size until it covers the total weight and four buckets per
   // member, and fills each bucket by comparing weight/divisor quotients
   // exactly with two products per candidate. A select masks the hash, probes
   // the bucket store forward and stops at a live member or after every bucket.
   whbt_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .flags            (flags),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_func         (req_func),
      .req_member_index (req_member_index),
      .req_weight       (req_weight),
      .req_member_count (req_member_count),
      .req_alive        (req_alive),
      .req_hash         (req_hash),
      .rsp_status       (rsp_status),
      .rsp_table_size   (rsp_table_size),
      .rsp_member       (rsp_member)
   );

endmodule

@@ tb/weighted_hash_bucket_table_test.sv @@
// ----------------------------------------------------------------------------
// Weighted hash bucket table testbench
// Drives load, build, alive and select transactions into the bucket table and
// checks every response against an in-bench predictor of the apportionment
// and probe logic. The size limit register is changed between phases.
// ----------------------------------------------------------------------------
module weighted_hash_bucket_table_test;
   import whbt_pkg::*;

   // One request transaction as it appears on the req_ ports.
   typedef struct {
      func_type    func;
      logic [3:0]  idx;
      logic [31:0] weight;
      logic [4:0]  count;
      logic        alive;
      logic [31:0] hash;
   } request_type;

   // One response transaction as it appears on the rsp_ ports.
   typedef struct {
      status_type status;
      logic [8:0] size;
      logic [3:0] member;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = '0;
   logic [3:0]  req_member_index = '0;
   logic [31:0] req_weight = '0;
   logic [4:0]  req_member_count = '0;
   logic        req_alive = 1'b0;
   logic [31:0] req_hash = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [8:0]  rsp_table_size;
   logic [3:0]  rsp_member;

   weighted_hash_bucket_table uut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_member_index(req_member_index),
      .req_weight(req_weight), .req_member_count(req_member_count),
      .req_alive(req_alive), .req_hash(req_hash),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_table_size(rsp_table_size),
      .rsp_member(rsp_member)
   );

   always #2 clock = ~clock;

   // Requests waiting to be driven, and the responses the predictor says
   // are still owed by the block, oldest first.
   request_type pending_requests[$];
   answer_type  owed_answers[$];
   request_type cur_req;
   int       errors = 0;
   bit       idling = 1'b0;   // when clear, neither side inserts gaps or stalls

   // Predictor state: a private copy of everything the block remembers.
   logic [31:0] pw_weight[MAX_MEMBERS];
   int unsigned pw_divisor[MAX_MEMBERS];
   logic [3:0]  pw_bucket[MAX_BUCKETS];
   int unsigned pw_buckets = 0;
   logic [15:0] pw_alive = '1;
   logic [16:0] pw_limit = '0;

   // Size the table and hand out buckets by odd-divisor apportionment. Any
   // failure removes the current table.
   function automatic status_type apportion_table(int unsigned cnt);
      longint unsigned total, wmin, w, slots, floor4, size, lhs, rhs;
      int unsigned win;
      pw_buckets = 0;
      if (cnt == 0 || cnt > MAX_MEMBERS) return ST_BAD_COUNT;
      total = 0;
      wmin = 0;
      for (int i = 0; i < cnt; i++) begin
         w = pw_weight[i];
         if (w != 0 && (wmin == 0 || w < wmin)) wmin = w;
         total += w;
         pw_divisor[i] = 1;
      end
      if (total == 0) return ST_ZERO_WEIGHT;
      slots = (total + wmin - 1) / wmin;
      floor4 = cnt * 4;
      if (floor4 > MAX_BUCKETS) floor4 = MAX_BUCKETS;
      if (floor4 > slots) slots = floor4;
      size = MIN_SIZE;
      while (size < slots && size <= MAX_BUCKETS) size <<= 1;
      if (size > MAX_BUCKETS || (pw_limit != 0 && size > pw_limit)) return ST_TOO_LARGE;
      for (int b = 0; b < size; b++) begin
         win = 0;
         // Exact quotient comparison; a tie keeps the lower member index.
         for (int i = 1; i < cnt; i++) begin
            lhs = pw_weight[i];
            lhs = lhs * pw_divisor[win];
            rhs = pw_weight[win];
            rhs = rhs * pw_divisor[i];
            if (lhs > rhs) win = i;
         end
         pw_divisor[win] += 2;
         pw_bucket[b] = win[3:0];
      end
      pw_buckets = 32'(size);
      return ST_OK;
   endfunction

   // Mask the hash to a bucket and probe forward, wrapping, to a live member.
   function automatic answer_type pick_member(logic [31:0] hash);
      answer_type a;
      int unsigned mask, start;
      logic [3:0] cand;
      a.status = ST_NO_MEMBER;
      a.size = pw_buckets[8:0];
      a.member = '0;
      if (pw_buckets == 0) return a;
      mask = pw_buckets - 1;
      start = hash & mask;
      for (int i = 0; i < pw_buckets; i++) begin
         cand = pw_bucket[(start + i) & mask];
         if (pw_alive[cand]) begin
            a.status = ST_OK;
            a.member = cand;
            return a;
         end
      end
      return a;
   endfunction

   // Apply one accepted request to the predictor and return its response.
   function automatic answer_type apply_request(request_type r);
      answer_type a;
      a.status = ST_OK;
      a.member = '0;
      case (r.func)
         FUNC_LOAD:   pw_weight[r.idx] = r.weight;
         FUNC_BUILD:  a.status = apportion_table(r.count);
         FUNC_ALIVE:  pw_alive[r.idx] = r.alive;
         FUNC_SELECT: a = pick_member(r.hash);
      endcase
      a.size = pw_buckets[8:0];
      return a;
   endfunction

   // Driver: presents queued requests, holds a stalled payload, and inserts
   // a random gap after each accepted transaction while idling is enabled.
   int unsigned send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            owed_answers.push_back(apply_request(cur_req));
            send_gap = idling ? $urandom_range(0, 11) : 0;
         end
         if (req_valid && req_stall) begin
            // A stalled payload stays put.
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            cur_req = pending_requests.pop_front();
            req_func <= cur_req.func;
            req_member_index <= cur_req.idx;
            req_weight <= cur_req.weight;
            req_member_count <= cur_req.count;
            req_alive <= cur_req.alive;
            req_hash <= cur_req.hash;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compares each accepted response with the oldest owed one and
   // draws a stall for the response after it.
   int unsigned hold_cnt = 0;
   answer_type want;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_answers.size() == 0) begin
               $display("%0t: unexpected response status=%0d size=%0d member=%0d",
                        $time, rsp_status, rsp_table_size, rsp_member);
               errors++;
            end else begin
               want = owed_answers.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_status);
                  errors++;
               end
               if (rsp_table_size !== want.size) begin
                  $display("%0t: table_size expected %0d actual %0d", $time, want.size,
                           rsp_table_size);
                  errors++;
               end
               if (rsp_member !== want.member) begin
                  $display("%0t: member expected %0d actual %0d", $time, want.member,
                           rsp_member);
                  errors++;
               end
            end
            hold_cnt = idling ? $urandom_range(0, 11) : 0;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add(func_type f, int unsigned idx, logic [31:0] w, int unsigned cnt,
                      int unsigned al, logic [31:0] h);
      request_type r;
      r.func = f;
      r.idx = idx[3:0];
      r.weight = w;
      r.count = cnt[4:0];
      r.alive = al[0];
      r.hash = h;
      pending_requests.push_back(r);
   endtask

   // Wait until every request is taken and every response has come back,
   // then let the block settle.
   task automatic drain();
      while (pending_requests.size() > 0 || req_valid || owed_answers.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_limit(logic [16:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      pw_limit = v;
   endtask

   // Small weights keep most tables within range; a few full-width ones and
   // zeros reach the oversized and zero-weight paths.
   function automatic logic [31:0] draw_weight();
      int unsigned k;
      k = $urandom_range(0, 15);
      if (k == 0) return 32'd0;
      if (k == 1) return $urandom;
      return $urandom_range(1, 12);
   endfunction

   // Mostly well-formed sequences: load weights, build, flip some alive
   // bits, then a burst of selects. The rest is random noise.
   task automatic random_phase(int unsigned n_items);
      int unsigned made, cnt;
      made = 0;
      while (made < n_items) begin
         if ($urandom_range(0, 9) < 7) begin
            cnt = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 5);
            for (int i = 0; i < cnt; i++) add(FUNC_LOAD, i, draw_weight(), 0, 0, $urandom);
            add(FUNC_BUILD, $urandom_range(0, 15), $urandom, cnt, $urandom_range(0, 1),
                $urandom);
            made += cnt + 1;
            for (int i = $urandom_range(0, 3); i > 0; i--) begin
               add(FUNC_ALIVE, $urandom_range(0, cnt - 1), $urandom, $urandom_range(0, 31),
                   ($urandom_range(0, 3) != 0) ? 1 : 0, $urandom);
               made++;
            end
            for (int i = $urandom_range(5, 15); i > 0; i--) begin
               add(FUNC_SELECT, $urandom_range(0, 15), $urandom, $urandom_range(0, 31),
                   $urandom_range(0, 1), $urandom);
               made++;
            end
         end else begin
            add(func_type'($urandom_range(0, 3)), $urandom_range(0, 15), draw_weight(),
                $urandom_range(0, 31), $urandom_range(0, 1), $urandom);
            made++;
         end
      end
   endtask

   logic [16:0] limits[7];

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the size limit at its reset value of zero.
      add(FUNC_SELECT, 0, 0, 0, 0, 32'hFFFF_FFFF);           // select before any table
      add(FUNC_BUILD, 0, 0, 0, 0, 0);                         // member count zero
      add(FUNC_BUILD, 0, 0, 17, 0, 0);                        // one above the maximum
      add(FUNC_BUILD, 15, 32'hFFFF_FFFF, 31, 1, 0);           // largest encodable count
      add(FUNC_BUILD, 0, 0, 2, 0, 0);                         // all weights still zero
      add(FUNC_LOAD, 15, 32'hFFFF_FFFF, 0, 1, 32'hFFFF_FFFF);
      add(FUNC_LOAD, 0, 32'd1, 0, 0, 0);
      add(FUNC_BUILD, 0, 0, 16, 0, 0);                        // huge ratio, too large
      add(FUNC_SELECT, 0, 0, 0, 0, 32'd5);                    // failed build left no table
      add(FUNC_LOAD, 0, 32'd3, 0, 0, 0);
      add(FUNC_LOAD, 1, 32'd1, 0, 0, 0);
      add(FUNC_BUILD, 0, 0, 2, 0, 0);                         // minimum sized table
      add(FUNC_SELECT, 0, 0, 0, 0, 32'd0);
      add(FUNC_SELECT, 0, 0, 0, 0, 32'hFFFF_FFFF);
      add(FUNC_ALIVE, 0, 0, 0, 0, 0);
      add(FUNC_SELECT, 0, 0, 0, 0, 32'd3);                    // probe skips a dead member
      add(FUNC_ALIVE, 1, 0, 0, 0, 0);
      add(FUNC_SELECT, 0, 0, 0, 0, 32'd7);                    // nobody alive
      add(FUNC_ALIVE, 0, 0, 0, 1, 0);
      add(FUNC_ALIVE, 1, 0, 0, 1, 0);
      add(FUNC_LOAD, 1, 32'd3, 0, 0, 0);
      add(FUNC_BUILD, 0, 0, 2, 0, 0);                         // equal weights, ties
      add(FUNC_SELECT, 0, 0, 0, 0, 32'hA5A5_5A5A);
      drain();

      // Each phase runs under a new size limit, extremes included; the
      // drain before each write is also the sender's full pause.
      limits = '{17'd16, 17'd64, 17'd17, 17'd256, 17'd65536, 17'd1, 17'd0};
      limits[6] = 17'($urandom_range(0, 65536));
      foreach (limits[p]) begin
         write_limit(limits[p]);
         idling = (p % 3) != 2;
         random_phase(218);
         drain();
      end
      write_limit(17'd65535);
      idling = 1'b1;
      random_phase(20);
      drain();

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
